### src/tkst_pkg.sv
package tkst_pkg;

    // Command codes carried on the request tuser
    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // One ranked entry handed from cell to cell
    typedef struct packed {
        logic        [31:0] user;
        logic signed [31:0] score;
    } entry_t;

    // Per-cell control from the top level
    typedef struct packed {
        logic ins_en;   // an add is being inserted this cycle
        logic active;   // cell holds a kept entry
    } cell_ctrl_t;

    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 104;
    localparam int unsigned KEPT_W     = 7;
    localparam int unsigned TOTAL_W    = 32;

endpackage

### src/tkst_cell.sv
module tkst_cell (
    input  logic                       clk,
    input  tkst_pkg::cell_ctrl_t       ctrl,
    input  tkst_pkg::entry_t           new_entry,
    input  logic                       prev_stay,
    input  tkst_pkg::entry_t           prev_entry,
    output logic                       stay,
    output tkst_pkg::entry_t           entry
);
    import tkst_pkg::*;

    entry_t entry_reg;

    // Hold while kept and ranked at or above the new score
    assign stay  = ctrl.active && (entry_reg.score >= new_entry.score);
    assign entry = entry_reg;

    // Take the new request at the insertion point, shift down below it
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en && !stay)
        begin
            if (prev_stay)
            begin
                entry_reg <= new_entry;
            end
            else
            begin
                entry_reg <= prev_entry;
            end
        end
    end

endmodule

### src/top_k_score_tracker.sv
// Top-k score tracker: a row of MAX_KEEP ranking cells, one entry per cell.
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; every cell compares
// against the new score in parallel and shifts into its neighbor in that same cycle.
// Reset (rst_n low, asynchronous): list empty, total zero, keep_count 10;
// the cell contents are left undefined and are never read before written.
module top_k_score_tracker #(
    parameter int unsigned MAX_KEEP = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // user_id [31:0], score [63:32], rank_index [69:64], zero pad
    input  logic [tkst_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // command [1:0]
    input  logic [1:0]                           s_axis_tuser,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_user [31:0], entry_score [63:32], entries_kept [70:64],
    // total_added [102:71], zero pad
    output logic [tkst_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // entry_valid [0]
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 cfg_wr_en,
    input  logic [6:0]                           cfg_wr_data
);
    import tkst_pkg::*;

    localparam int unsigned KW = $clog2(MAX_KEEP + 1);

    logic [6:0]          keep_count_reg;
    logic [KW-1:0]       kept_reg, kept_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_flag_reg, out_flag_next;

    logic                accept;
    cmd_t                cmd;
    entry_t              new_entry;
    logic [5:0]          rank;
    logic [KW-1:0]       lim, cfg_lim;
    logic                full, any_open, ins_en;
    logic                rd_hit;
    entry_t              rd_entry;

    logic   [MAX_KEEP-1:0] stay;
    logic   [MAX_KEEP-1:0] active;
    entry_t                entries [MAX_KEEP];

    // Clamp a keep_count value into 1..MAX_KEEP
    function automatic logic [KW-1:0] lim_of(input logic [6:0] k);
        logic [KW-1:0] r;
        if (k == 7'd0)
        begin
            r = KW'(1);
        end
        else if (32'(k) > MAX_KEEP)
        begin
            r = KW'(MAX_KEEP);
        end
        else
        begin
            r = KW'(k);
        end
        return r;
    endfunction

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd           = cmd_t'(s_axis_tuser);
    assign new_entry.user  = s_axis_tdata[31:0];
    assign new_entry.score = s_axis_tdata[63:32];
    assign rank          = s_axis_tdata[69:64];

    assign lim      = lim_of(keep_count_reg);
    assign cfg_lim  = lim_of(cfg_wr_data);
    assign full     = kept_reg >= lim;
    assign any_open = |(active & ~stay);
    assign ins_en   = accept && (cmd == CMD_ADD) && (!full || any_open);

    // Build the cell row
    for (genvar i = 0; i < MAX_KEEP; i++)
    begin : g_cell
        cell_ctrl_t ctrl;
        logic       p_stay;
        entry_t     p_entry;

        assign active[i]   = 32'(kept_reg) > i;
        assign ctrl.ins_en = ins_en;
        assign ctrl.active = active[i];

        if (i == 0)
        begin : g_head
            assign p_stay  = 1'b1;
            assign p_entry = new_entry;
        end
        else
        begin : g_body
            assign p_stay  = stay[i-1];
            assign p_entry = entries[i-1];
        end

        tkst_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_stay  (p_stay),
            .prev_entry (p_entry),
            .stay       (stay[i]),
            .entry      (entries[i])
        );
    end

    // Select the entry at the requested rank
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < MAX_KEEP; i++)
        begin
            if (32'(rank) == i)
            begin
                rd_entry = entries[i];
            end
        end
    end

    assign rd_hit = 32'(rank) < 32'(kept_reg);

    // Next count, total and result
    always_comb
    begin
        kept_next     = kept_reg;
        total_next    = total_reg;
        out_flag_next = 1'b0;
        out_data_next = '0;
        unique case (cmd)
            CMD_ADD:
            begin
                if (total_reg != '1)
                begin
                    total_next = total_reg + TOTAL_W'(1);
                end
                if (!full)
                begin
                    kept_next = kept_reg + KW'(1);
                end
            end
            CMD_READ:
            begin
                if (rd_hit)
                begin
                    out_flag_next        = 1'b1;
                    out_data_next[31:0]  = rd_entry.user;
                    out_data_next[63:32] = rd_entry.score;
                end
            end
            CMD_CLEAR:
            begin
                kept_next  = '0;
                total_next = '0;
            end
            default:
            begin
                kept_next = kept_reg;
            end
        endcase
        out_data_next[70:64]  = KEPT_W'(kept_next);
        out_data_next[102:71] = total_next;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= 7'd10;
            kept_reg       <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                keep_count_reg <= cfg_wr_data;
                if (kept_reg > cfg_lim)
                begin
                    kept_reg <= cfg_lim;
                end
            end
            else if (accept)
            begin
                kept_reg <= kept_next;
            end
            if (accept)
            begin
                total_reg <= total_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
            out_flag_reg <= out_flag_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;

    // Checks
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd == CMD_CLEAR) |=> (kept_reg == '0) && (total_reg == '0))
        else $error("clear did not empty the list");

    a_kept_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= lim)
        else $error("kept count exceeds the keep limit");

    a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd != CMD_CLEAR) |=> total_reg >= $past(total_reg))
        else $error("total decreased without clear");

    a_hit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[70:64] != 7'd0)
        else $error("read hit on an empty list");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tkst_pkg::*;

    localparam int unsigned RANK_DEPTH = 64;
    localparam int unsigned ITEM_GOAL  = 1500;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;

    // One request as it travels on the slave side
    typedef struct {
        logic        [1:0]  cmd;
        logic        [31:0] user;
        logic signed [31:0] score;
        logic        [5:0]  rank;
    } score_req_t;

    // One result as it travels on the master side
    typedef struct {
        logic               valid;
        logic        [31:0] user;
        logic signed [31:0] score;
        logic        [6:0]  kept;
        logic        [31:0] total;
    } rank_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [6:0]            cfg_wr_data   = '0;

    // Stimulus and scoreboard state
    score_req_t   queued_reqs[$];
    rank_result_t predicted_results[$];
    logic         req_fired = 1'b0;
    int           src_wait  = 0;
    int           sink_wait = 0;
    bit           src_mode  = 1'b0;
    bit           sink_mode = 1'b0;

    // Shadow copy of the ranking
    logic        [31:0] rank_user  [RANK_DEPTH];
    logic signed [31:0] rank_score [RANK_DEPTH];
    logic        [6:0]  keep_reg   = 7'd10;
    int unsigned        kept_now   = 0;
    logic        [31:0] offered_now = '0;

    // Run statistics
    int errors     = 0;
    int n_queued   = 0;
    int n_results  = 0;
    int n_adds     = 0;
    int n_inserted = 0;
    int n_hits     = 0;
    int n_cfg      = 0;
    int max_kept   = 0;

    top_k_score_tracker #(
        .MAX_KEEP(RANK_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Effective list length for a keep_count value
    function automatic int unsigned keep_limit(logic [6:0] k);
        if (k == 0)
            return 1;
        if (k > RANK_DEPTH)
            return RANK_DEPTH;
        return 32'(k);
    endfunction

    // Apply one request to the shadow ranking and build its result
    task automatic rank_update(input score_req_t req, output rank_result_t res);
        int unsigned lim;
        int unsigned last;
        int unsigned pos;
        int unsigned i;
        bit          insert;
        res = '{default: '0};
        case (req.cmd)
            CMD_ADD:
            begin
                n_adds++;
                if (offered_now != 32'hFFFF_FFFF)
                    offered_now++;
                lim    = keep_limit(keep_reg);
                insert = 1'b1;
                last   = 0;
                if (kept_now >= lim)
                begin
                    // full list: only a strictly higher score displaces the lowest
                    if (req.score > rank_score[lim - 1])
                        last = lim - 1;
                    else
                        insert = 1'b0;
                end
                else
                begin
                    last = kept_now;
                    kept_now++;
                end
                if (insert)
                begin
                    // ties go after the kept equal scores
                    pos = 0;
                    while (pos < last && rank_score[pos] >= req.score)
                        pos++;
                    for (i = last; i > pos; i--)
                    begin
                        rank_user[i]  = rank_user[i - 1];
                        rank_score[i] = rank_score[i - 1];
                    end
                    rank_user[pos]  = req.user;
                    rank_score[pos] = req.score;
                    n_inserted++;
                end
            end
            CMD_READ:
            begin
                if (req.rank < kept_now)
                begin
                    res.valid = 1'b1;
                    res.user  = rank_user[req.rank];
                    res.score = rank_score[req.rank];
                    n_hits++;
                end
            end
            CMD_CLEAR:
            begin
                kept_now    = 0;
                offered_now = '0;
            end
            default: ;
        endcase
        res.kept  = 7'(kept_now);
        res.total = offered_now;
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    // Length of one stall: mostly short, a few long
    function automatic int stall_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic score_req_t mk_req(logic [1:0] cmd, logic [31:0] user,
                                          logic signed [31:0] score, logic [5:0] rank);
        score_req_t r;
        r.cmd   = cmd;
        r.user  = user;
        r.score = score;
        r.rank  = rank;
        return r;
    endfunction

    // Random request; ranks lean toward the kept region
    function automatic score_req_t random_req(int unsigned lim, int unsigned clear_pm);
        score_req_t  r;
        int unsigned pick;
        pick    = $urandom_range(0, 999);
        r.user  = $urandom;
        r.score = $urandom;
        r.rank  = 6'($urandom_range(0, 63));
        if (pick < clear_pm)
            r.cmd = CMD_CLEAR;
        else if (pick < 620)
        begin
            r.cmd = CMD_ADD;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r.score = int'($urandom_range(0, 16)) - 8;
                8:          r.score = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                9:          r.score = $urandom_range(0, 3) * 1000;
                default: ;
            endcase
        end
        else if (pick < 970)
        begin
            r.cmd = CMD_READ;
            if ($urandom_range(0, 9) < 7)
                r.rank = 6'($urandom_range(0, (lim < 63) ? lim : 63));
        end
        else
            r.cmd = CMD_UNUSED;
        return r;
    endfunction

    task automatic queue_req(input score_req_t r);
        queued_reqs.insert(queued_reqs.size(), r);
        n_queued++;
    endtask

    // Wait until every request is taken and every result is back
    task automatic drain();
        @(negedge clk);
        while (queued_reqs.size() != 0 || predicted_results.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Write keep_count while the block is idle
    task automatic set_keep(input logic [6:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Request driver: hold until taken, then gap or advance
    always @(negedge clk)
    begin
        score_req_t nxt;
        if (req_fired && src_mode && $urandom_range(0, 99) < 40)
            src_wait = stall_len();
        if (s_axis_tvalid && !req_fired)
        begin
        end
        else if (src_wait > 0)
        begin
            src_wait--;
            s_axis_tvalid <= 1'b0;
        end
        else if (queued_reqs.size() != 0)
        begin
            nxt = queued_reqs[0];
            s_axis_tuser  <= nxt.cmd;
            s_axis_tdata  <= {2'b00, nxt.rank, nxt.score, nxt.user};
            s_axis_tvalid <= 1'b1;
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Result sink: stall at random
    always @(negedge clk)
    begin
        if (sink_wait == 0 && sink_mode && $urandom_range(0, 3) == 0)
            sink_wait = stall_len();
        if (sink_wait > 0)
        begin
            sink_wait--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Scoreboard: check results, predict accepted requests, track config
    always @(posedge clk)
    begin
        rank_result_t got;
        rank_result_t want;
        score_req_t   req;
        int unsigned  lim;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.valid = m_axis_tuser;
                got.user  = m_axis_tdata[31:0];
                got.score = m_axis_tdata[63:32];
                got.kept  = m_axis_tdata[70:64];
                got.total = m_axis_tdata[102:71];
                n_results++;
                if (predicted_results.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                begin
                    want = predicted_results.pop_front();
                    if (got.valid !== want.valid)
                        report_mismatch($sformatf("entry_valid got %b expected %b",
                                                  got.valid, want.valid));
                    if (got.user !== want.user)
                        report_mismatch($sformatf("entry_user got %h expected %h",
                                                  got.user, want.user));
                    if (got.score !== want.score)
                        report_mismatch($sformatf("entry_score got %0d expected %0d",
                                                  got.score, want.score));
                    if (got.kept !== want.kept)
                        report_mismatch($sformatf("entries_kept got %0d expected %0d",
                                                  got.kept, want.kept));
                    if (got.total !== want.total)
                        report_mismatch($sformatf("total_added got %0d expected %0d",
                                                  got.total, want.total));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                req.cmd   = s_axis_tuser;
                req.user  = s_axis_tdata[31:0];
                req.score = s_axis_tdata[63:32];
                req.rank  = s_axis_tdata[69:64];
                rank_update(req, want);
                predicted_results.insert(predicted_results.size(), want);
                if (queued_reqs.size() != 0)
                    void'(queued_reqs.pop_front());
                if (kept_now > max_kept)
                    max_kept = kept_now;
            end
            if (cfg_wr_en)
            begin
                // lowering the limit cuts the list at once
                keep_reg = cfg_wr_data;
                lim      = keep_limit(keep_reg);
                if (kept_now > lim)
                    kept_now = lim;
                n_cfg++;
            end
        end
        req_fired <= s_axis_tvalid && s_axis_tready;
    end

    // Stimulus sequence
    initial
    begin
        int          phase_no;
        int          len;
        int unsigned lim;
        int unsigned clear_pm;
        logic [6:0]  kv;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, extreme scores, ties, unused command, past-end read
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd0));
        queue_req(mk_req(CMD_ADD, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 6'd0));
        queue_req(mk_req(CMD_ADD, 32'h0, 32'sh8000_0000, 6'd63));
        queue_req(mk_req(CMD_ADD, 32'h1, 32'sh0, 6'd0));
        queue_req(mk_req(CMD_ADD, 32'h2, 32'sh0, 6'd0));
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd1));
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd2));
        queue_req(mk_req(CMD_READ, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 6'd63));
        queue_req(mk_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 6'd63));
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd0));
        for (int s = 10; s < 16; s++)
            queue_req(mk_req(CMD_ADD, 32'h100 + s, s, 6'd0));
        // full list: a score equal to the lowest stays out
        queue_req(mk_req(CMD_ADD, 32'hDEAD_BEEF, 32'sh8000_0000, 6'd0));
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd9));
        queue_req(mk_req(CMD_CLEAR, 32'h0, 32'sh0, 6'd0));
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd0));

        set_keep(7'd3);
        queue_req(mk_req(CMD_ADD, 32'hA, 32'sd50, 6'd0));
        queue_req(mk_req(CMD_ADD, 32'hB, 32'sd40, 6'd0));
        queue_req(mk_req(CMD_ADD, 32'hC, 32'sd60, 6'd0));
        queue_req(mk_req(CMD_ADD, 32'hD, 32'sd40, 6'd0));
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd2));

        // shrink to one entry while three are kept
        set_keep(7'd1);
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd0));
        queue_req(mk_req(CMD_READ, 32'h0, 32'sh0, 6'd1));

        // random phases, each under its own keep_count and idling pattern
        phase_no = 0;
        while (n_queued < ITEM_GOAL)
        begin
            case (phase_no)
                0: kv = 7'd0;
                1: kv = 7'd127;
                2: kv = 7'd64;
                3: kv = 7'd1;
                default:
                    case ($urandom_range(0, 5))
                        0: kv = 7'($urandom_range(0, 127));
                        1: kv = 7'($urandom_range(1, 8));
                        2: kv = 7'd64;
                        3: kv = 7'($urandom_range(60, 70));
                        4: kv = 7'd10;
                        default: kv = 7'($urandom_range(0, 3));
                    endcase
            endcase
            set_keep(kv);
            src_mode  = ($urandom_range(0, 2) != 0);
            sink_mode = ($urandom_range(0, 2) != 0);
            lim      = keep_limit(kv);
            clear_pm = (lim > 16) ? 3 : 20;
            len      = $urandom_range(60, 200);
            repeat (len) queue_req(random_req(lim, clear_pm));
            phase_no++;
        end

        drain();
        $display("covered %0d requests and %0d results: %0d adds (%0d ranked in), %0d reads hit",
                 n_queued, n_results, n_adds, n_inserted, n_hits);
        $display("%0d keep_count writes over %0d random phases, deepest list %0d entries",
                 n_cfg, phase_no, max_kept);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
